// ===== hw/rtl/bctc_pkg.sv =====
// Package of shared constants and types for the CRC-32 trailer checker.
`default_nettype none
package bctc_pkg;

  localparam int unsigned CRC_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W = 3;

  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB8_8320;
  localparam logic [CNT_W-1:0] TRAILER_BYTES = 3'd4;

  // Register index decoded from the configuration address
  localparam logic REG_POLY = 1'b0;

  typedef struct packed {
    logic [CRC_W-1:0] payload_crc;
    logic block_too_short;
    logic trailer_match;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bctc_crc_byte.sv =====
// Byte-wide reflected CRC update: eight shift steps against a programmable polynomial.
`default_nettype none
module bctc_crc_byte (
  input  wire logic [bctc_pkg::CRC_W-1:0]  crc_i,
  input  wire logic [bctc_pkg::BYTE_W-1:0] byte_i,
  input  wire logic [bctc_pkg::CRC_W-1:0]  poly_i,
  output logic      [bctc_pkg::CRC_W-1:0]  crc_o
);

  always_comb begin
    logic [bctc_pkg::CRC_W-1:0] r;
    r = crc_i ^ {{(bctc_pkg::CRC_W - bctc_pkg::BYTE_W){1'b0}}, byte_i};
    for (int k = 0; k < bctc_pkg::BYTE_W; k++) begin
      // shift right, fold the polynomial in when the dropped bit is set
      r = r[0] ? (poly_i ^ (r >> 1)) : (r >> 1);
    end
    crc_o = r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bctc_cfg_regs.sv =====
// APB-style configuration register file holding the reflected polynomial.
`default_nettype none
module bctc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output logic      [bctc_pkg::CRC_W-1:0]  poly_o
);

  logic [bctc_pkg::CRC_W-1:0] poly_r;
  logic [bctc_pkg::CRC_W-1:0] poly_nxt;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    poly_nxt = poly_r;
    if (wr_en) begin
      unique case (paddr[2])
        bctc_pkg::REG_POLY: poly_nxt = pwdata;
        default:            poly_nxt = poly_r;  // out of range: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bctc_pkg::REG_POLY: prdata = poly_r;
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= bctc_pkg::POLY_RESET;
    end else begin
      poly_r <= poly_nxt;
    end
  end

  assign poly_o = poly_r;

endmodule
`default_nettype wire

// ===== hw/rtl/block_crc32_trailer_check.sv =====
// Top level of the CRC-32 trailer checker: input register, CRC stage, result register.
//
//  channel | direction | tdata             | tuser / tlast
//  --------+-----------+-------------------+-----------------------------------------
//  in_     | slave     | [7:0] data_byte   | tlast = last_byte
//  out_    | master    | [31:0] payload_crc| tuser[0] trailer_match, [1] block_too_short
//  cfg_    | APB slave | 32-bit data       | reg 0 reflected_polynomial at 0x0
//
// One byte per cycle while the result channel is not stalled; a byte lands in the
// input register, then the CRC stage (one byte-wide CRC update plus a 32-bit compare)
// works on it when the stage advances, and registers the result on a block's final byte.
// Synchronous active-low reset: CRC to all ones, delay line, count and both valids cleared.
// A stalled result holds the CRC stage; the input register still takes one byte.
`default_nettype none
module block_crc32_trailer_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] payload_crc
  output logic      [1:0]  out_tuser,  // [0] trailer_match, [1] block_too_short
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned CW = bctc_pkg::CRC_W;
  localparam int unsigned BW = bctc_pkg::BYTE_W;
  localparam int unsigned NW = bctc_pkg::CNT_W;

  logic [CW-1:0] poly;

  bctc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .poly_o  (poly)
  );

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic          in_valid_r;
  logic [BW-1:0] in_byte_r;
  logic          in_last_r;
  logic          in_fire;
  logic          stage_fire;

  assign in_fire = in_tvalid && in_tready;

  // Advance the CRC stage when the result register is free or being drained.
  assign stage_fire = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready  = !in_valid_r || stage_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // CRC stage: block state and per-byte update
  // ---------------------------------------------------------------------------
  logic [CW-1:0] crc_acc_r, crc_acc_nxt;
  logic [CW-1:0] delay_r, delay_nxt;
  logic [NW-1:0] seen_r, seen_nxt;
  logic [CW-1:0] crc_fed;
  logic [CW-1:0] crc_upd;
  logic [CW-1:0] dl_upd;
  logic [NW-1:0] seen_upd;
  bctc_pkg::result_t res;

  // The oldest held byte leaves the delay line and enters the CRC.
  bctc_crc_byte u_crc (
    .crc_i  (crc_acc_r),
    .byte_i (delay_r[BW-1:0]),
    .poly_i (poly),
    .crc_o  (crc_fed)
  );

  always_comb begin
    crc_upd  = (seen_r >= bctc_pkg::TRAILER_BYTES) ? crc_fed : crc_acc_r;
    dl_upd   = {in_byte_r, delay_r[CW-1:BW]};
    seen_upd = (seen_r < bctc_pkg::TRAILER_BYTES) ? seen_r + NW'(1) : seen_r;

    res.payload_crc     = crc_upd ^ bctc_pkg::CRC_ALL_ONES;
    res.block_too_short = seen_upd < bctc_pkg::TRAILER_BYTES;
    res.trailer_match   = !res.block_too_short && (dl_upd == res.payload_crc);

    crc_acc_nxt = crc_acc_r;
    delay_nxt   = delay_r;
    seen_nxt    = seen_r;
    if (stage_fire) begin
      if (in_last_r) begin
        // end of block: return to the reset state for the next one
        crc_acc_nxt = bctc_pkg::CRC_ALL_ONES;
        delay_nxt   = '0;
        seen_nxt    = '0;
      end else begin
        crc_acc_nxt = crc_upd;
        delay_nxt   = dl_upd;
        seen_nxt    = seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_acc_r <= bctc_pkg::CRC_ALL_ONES;
      delay_r   <= '0;
      seen_r    <= '0;
    end else begin
      crc_acc_r <= crc_acc_nxt;
      delay_r   <= delay_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              out_valid_r;
  bctc_pkg::result_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_fire) begin
      out_valid_r <= in_last_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.payload_crc;
  assign out_tuser  = {out_res_r.block_too_short, out_res_r.trailer_match};

`ifndef SYNTHESIS
  a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= bctc_pkg::TRAILER_BYTES)
    else $error("byte count passed saturation");

  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0 && !out_tuser[0]))
    else $error("short block result carries CRC or match");

  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && in_last_r) |=> (seen_r == '0 && crc_acc_r == bctc_pkg::CRC_ALL_ONES
                                   && delay_r == '0))
    else $error("block state not cleared after final byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/crc_trailer_monitor.sv =====
// Monitor for the CRC-32 trailer checker: predicts each block verdict and compares results.
module crc_trailer_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] payload_crc
  input  logic [1:0]  out_tuser,  // [0] trailer_match, [1] block_too_short
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]       poly_copy;
  logic [31:0]       crc_acc;
  logic [31:0]       trailer_window;   // newest byte in [31:24]
  logic [2:0]        bytes_held;       // saturates at four
  bctc_pkg::result_t expected_verdicts[$];
  bctc_pkg::result_t verdict;
  int                mismatches = 0;

  assign mismatch_count = mismatches;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      poly_copy      = bctc_pkg::POLY_RESET;
      crc_acc        = bctc_pkg::CRC_ALL_ONES;
      trailer_window = '0;
      bytes_held     = '0;
      expected_verdicts.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        // The oldest held byte leaves the window and enters the CRC.
        if (bytes_held >= bctc_pkg::TRAILER_BYTES) begin
          crc_acc ^= {24'd0, trailer_window[7:0]};
          for (int k = 0; k < 8; k++)
            crc_acc = crc_acc[0] ? (poly_copy ^ (crc_acc >> 1)) : (crc_acc >> 1);
        end
        trailer_window = {in_tdata, trailer_window[31:8]};
        if (bytes_held < bctc_pkg::TRAILER_BYTES) bytes_held++;
        if (in_tlast) begin
          verdict.payload_crc     = crc_acc ^ bctc_pkg::CRC_ALL_ONES;
          verdict.block_too_short = bytes_held < bctc_pkg::TRAILER_BYTES;
          verdict.trailer_match   = !verdict.block_too_short &&
                                    (trailer_window == verdict.payload_crc);
          expected_verdicts.push_back(verdict);
          crc_acc        = bctc_pkg::CRC_ALL_ONES;
          trailer_window = '0;
          bytes_held     = '0;
        end
      end

      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result with no block pending", out_tdata, '0);
        end else begin
          verdict = expected_verdicts.pop_front();
          if (out_tdata !== verdict.payload_crc)
            flag_mismatch("payload_crc", out_tdata, verdict.payload_crc);
          if (out_tuser[0] !== verdict.trailer_match)
            flag_mismatch("trailer_match", 32'(out_tuser[0]), 32'(verdict.trailer_match));
          if (out_tuser[1] !== verdict.block_too_short)
            flag_mismatch("block_too_short", 32'(out_tuser[1]),
                          32'(verdict.block_too_short));
        end
      end

      // Unmapped register indexes are ignored on write and not checked on read.
      if (cfg_psel && cfg_penable && cfg_pready &&
          ((cfg_paddr >> 2) == 3'(bctc_pkg::REG_POLY))) begin
        if (cfg_pwrite) begin
          poly_copy = cfg_pwdata;
        end else if (cfg_prdata !== poly_copy) begin
          flag_mismatch("polynomial readback", cfg_prdata, poly_copy);
        end
      end
    end
    pending_results <= expected_verdicts.size();
  end

endmodule

// ===== tb/sv/block_crc32_trailer_check_tb.sv =====
// Testbench top for the CRC-32 trailer checker: clock, reset, stimulus and verdict.
module block_crc32_trailer_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map: the polynomial sits at index 0, index 1 is unmapped.
  localparam logic [2:0]  POLY_ADDR       = 3'd0;
  localparam logic [2:0]  UNMAPPED_ADDR   = 3'd4;
  localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;
  // Give the pipeline a comfortable margin after the last result.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PHASE_BYTES  = 250;
  localparam int NUM_PHASES   = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] data_byte
  logic        in_tlast = 1'b0;   // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] payload_crc
  logic [1:0]  out_tuser;         // [0] trailer_match, [1] block_too_short
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatch_count;
  int          pending_results;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [31:0] cur_poly = bctc_pkg::POLY_RESET;
  logic [7:0]  blk[$];            // bytes of the block being built

  block_crc32_trailer_check dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  crc_trailer_monitor monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result channel at random; a zero percentage keeps tready high.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one byte, idling first at random, and hold it until the transaction completes.
  // Leave tvalid high afterwards so back-to-back bytes need no extra step.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_block();
    foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1);
  endtask

  // Overwrite the last four bytes with the little-endian CRC of the rest,
  // under the polynomial currently programmed.
  function automatic void seal_trailer();
    logic [31:0] crc;
    crc = bctc_pkg::CRC_ALL_ONES;
    for (int i = 0; i + 4 < blk.size(); i++) begin
      crc ^= {24'd0, blk[i]};
      for (int k = 0; k < 8; k++) crc = crc[0] ? (cur_poly ^ (crc >> 1)) : (crc >> 1);
    end
    crc ^= bctc_pkg::CRC_ALL_ONES;
    for (int i = 0; i < 4; i++) blk[blk.size() - 4 + i] = crc[8*i +: 8];
  endfunction

  // Drop tvalid, wait until every expected result is in, then let the pipeline drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transaction: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic [2:0] addr, input logic write,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Program the polynomial and read it back; the monitor checks the readback.
  task automatic set_poly(input logic [31:0] value);
    apb_access(POLY_ADDR, 1'b1, value);
    apb_access(POLY_ADDR, 1'b0, '0);
    cur_poly = value;
  endtask

  initial begin
    int          phase_bytes;
    int          len;
    int          pick;
    logic [31:0] next_poly;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value readback, then a write to an unmapped index that must not stick.
    apb_access(POLY_ADDR, 1'b0, '0);
    apb_access(UNMAPPED_ADDR, 1'b1, 32'hFFFF_FFFF);
    apb_access(POLY_ADDR, 1'b0, '0);

    // Short blocks of one, two and three bytes: zero CRC, too-short flag, no match.
    blk = '{8'hFF};
    send_block();
    blk = '{8'h00, 8'hFF};
    send_block();
    blk = '{8'h80, 8'h01, 8'h7F};
    send_block();
    // Four zero bytes: empty payload gives CRC zero, which the zero trailer matches.
    blk = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_block();
    // One-byte payload with its proper trailer.
    blk = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    seal_trailer();
    send_block();

    // Change the polynomial mid-block: bytes still in the delay line see the new value.
    blk = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00};
    for (int i = 0; i < 6; i++) send_byte(blk[i], 1'b0);
    settle();
    set_poly(CASTAGNOLI_POLY);
    for (int i = 6; i < 9; i++) send_byte(blk[i], i == 8);

    // Random blocks, one idling pattern and polynomial per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;  next_poly = bctc_pkg::POLY_RESET;
        end
        1: begin
          send_idle_pct = 82; recv_stall_pct = 0;  next_poly = 32'h0000_0000;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 82; next_poly = 32'hFFFF_FFFF;
        end
        default: begin
          send_idle_pct = 9;  recv_stall_pct = 9;  next_poly = $urandom();
        end
      endcase
      set_poly(next_poly);

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        // Mostly mid-sized blocks, with short, trailer-only and long ones mixed in.
        pick = $urandom_range(9);
        if (pick == 0) len = $urandom_range(3, 1);
        else if (pick == 1) len = 4;
        else if (pick < 9) len = $urandom_range(24, 5);
        else len = $urandom_range(64, 25);

        blk.delete();
        repeat (len) blk.push_back(8'($urandom()));

        // Seal most trailers, corrupt a single bit in some, leave the rest as noise.
        pick = $urandom_range(9);
        if (len >= 4 && pick < 8) begin
          seal_trailer();
          if (pick >= 6) blk[len - 1 - $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        end

        send_block();
        phase_bytes += len;
      end
    end

    // Hold until every result has been checked, then give the verdict.
    settle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bctc_pkg.sv
hw/rtl/bctc_crc_byte.sv
hw/rtl/bctc_cfg_regs.sv
hw/rtl/block_crc32_trailer_check.sv
tb/sv/crc_trailer_monitor.sv
tb/sv/block_crc32_trailer_check_tb.sv
